// ===== rtl/tip_pkg.sv =====
// Shared types, constants and character helpers for the text to integer parser.
// No dependencies; every other file imports this package.
`default_nettype none

package tip_pkg;

    localparam int WORD_BITS   = 64;
    localparam int INDEX_BITS  = 16;
    localparam int VALUE_BITS  = 64;
    localparam int STATUS_BITS = 2;
    localparam int END_BITS    = 16;
    localparam int CHAR_BITS   = 8;
    localparam int BASE_BITS   = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int PROD_BITS   = WORD_BITS + BASE_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_BITS = 1;

    localparam logic [BASE_BITS-1:0]  BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0]  BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0]  BASE_ONE   = 6'd1;
    localparam logic [BASE_BITS-1:0]  BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0]  BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0]  BASE_HEX   = 6'd16;
    localparam logic [BASE_BITS-1:0]  BASE_MAX   = 6'd36;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd63;

    localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_BITS-1:0] CHAR_X_LO  = 8'h78;
    localparam logic [CHAR_BITS-1:0] CHAR_X_UP  = 8'h58;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2b;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2d;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NUMBER_BASE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_MODE = 1'b1;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_BODY,
        PH_ZERO,
        PH_ZEROX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK,
        ST_NO_DIGITS,
        ST_RANGE,
        ST_BAD_BASE
    } status_t;

    // one classified byte, front to back
    typedef struct packed {
        logic                  term;
        logic                  first;
        logic                  space;
        logic                  minus;
        logic                  plus;
        logic                  letter_x;
        logic [DIGIT_BITS-1:0] digit;
        logic [BASE_BITS-1:0]  base;
    } tip_item_t;

    function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        d = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39)
            d = DIGIT_BITS'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h7a)
            d = DIGIT_BITS'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h5a)
            d = DIGIT_BITS'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) ||
               (c == 8'h0d) || (c == 8'h0c) || (c == 8'h0b);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tip_front.sv =====
// Front end: accepts bytes, classifies them and pushes one item per byte into the queue.
// Depends on tip_pkg.
`default_nettype none

module tip_front
    import tip_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CHAR_BITS-1:0] char_in,
    input  wire logic [BASE_BITS-1:0] number_base,
    input  wire logic                 q_full,
    output logic                      push,
    output tip_item_t                 item
);

    logic first_reg;
    logic first_next;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    // first byte of a string samples the base register
    always_comb
    begin
        first_next = first_reg;
        if (push)
            first_next = (char_in == CHAR_NUL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_reg <= 1'b1;
        else
            first_reg <= first_next;
    end

    always_comb
    begin
        item.term     = (char_in == CHAR_NUL);
        item.first    = first_reg;
        item.space    = is_space(char_in);
        item.minus    = (char_in == CHAR_MINUS);
        item.plus     = (char_in == CHAR_PLUS);
        item.letter_x = (char_in == CHAR_X_LO) || (char_in == CHAR_X_UP);
        item.digit    = digit_of(char_in);
        item.base     = number_base;
    end

endmodule

`default_nettype wire

// ===== rtl/tip_queue.sv =====
// Short item queue between the front and back ends.
// Depends on tip_pkg.
`default_nettype none

module tip_queue
    import tip_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire tip_item_t wr_item,
    output logic           full,
    input  wire logic      pop,
    output logic           empty,
    output tip_item_t      rd_item
);

    tip_item_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCNT_BITS-1:0]   count_reg;
    logic [QCNT_BITS-1:0]   count_next;

    assign full    = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

`default_nettype wire

// ===== rtl/tip_back.sv =====
// Back end: parse state machine, digit accumulator and result register.
// Depends on tip_pkg.
`default_nettype none

module tip_back
    import tip_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tip_item_t              item,
    input  wire logic                   empty,
    output logic                        pop,
    input  wire logic                   signed_mode,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [VALUE_BITS-1:0]       value,
    output logic [STATUS_BITS-1:0]      status,
    output logic [END_BITS-1:0]         end_index
);

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [WORD_BITS-1:0]    acc_reg;
    logic [WORD_BITS-1:0]    acc_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic                    neg_reg;
    logic                    neg_next;
    logic [BASE_BITS-1:0]    base_reg;
    logic [BASE_BITS-1:0]    base_next;
    logic [INDEX_BITS-1:0]   byte_index_reg;
    logic [INDEX_BITS-1:0]   byte_index_next;
    logic [INDEX_BITS-1:0]   stop_index_reg;
    logic [INDEX_BITS-1:0]   stop_index_next;
    logic                    digit_seen_reg;
    logic                    digit_seen_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [VALUE_BITS-1:0]   value_next;
    status_t                 status_reg;
    status_t                 status_next;
    logic [END_BITS-1:0]     end_reg;
    logic [END_BITS-1:0]     end_next;

    logic [BASE_BITS-1:0]    base_cur;
    logic                    base_bad;
    logic [BASE_BITS-1:0]    mul_base;
    logic [PROD_BITS-1:0]    prod;
    logic                    prod_ovf;
    logic                    digit_ok;
    logic [INDEX_BITS-1:0]   idx_inc;
    logic                    take;
    logic                    zstart;
    logic                    neg_set;
    logic                    finish;

    logic [WORD_BITS-1:0]    lim;
    logic [WORD_BITS-1:0]    acc_neg;
    logic [WORD_BITS-1:0]    v_word;
    logic [31:0]             stop_ext;

    assign finish   = pop && item.term;
    assign pop      = !empty && (!item.term || !out_valid_reg || out_ready);
    assign base_cur = item.first ? item.base : base_reg;
    assign base_bad = (base_cur == BASE_ONE) || (base_cur > BASE_MAX);
    assign idx_inc  = (byte_index_reg == '1) ? byte_index_reg : byte_index_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            PH_ZEROX:          mul_base = BASE_HEX;
            PH_SPACE, PH_BODY: mul_base = (base_cur == BASE_AUTO) ? BASE_DEC : base_cur;
            default:           mul_base = base_cur;
        endcase
    end

    // acc * base + digit; anything above the word is overflow
    assign prod     = PROD_BITS'(acc_reg) * PROD_BITS'(mul_base) + PROD_BITS'(item.digit);
    assign prod_ovf = |prod[PROD_BITS-1:WORD_BITS];
    assign digit_ok = (item.digit < mul_base);

    // next state and action decode
    always_comb
    begin
        logic body_go;
        body_go    = 1'b0;
        phase_next = phase_reg;
        take       = 1'b0;
        zstart     = 1'b0;
        neg_set    = 1'b0;
        if (pop)
        begin
            if (item.term)
                phase_next = PH_SPACE;
            else
            begin
                case (phase_reg)
                    PH_SPACE:
                    begin
                        if (item.space)
                            phase_next = PH_SPACE;
                        else if (item.minus)
                        begin
                            neg_set    = 1'b1;
                            phase_next = PH_BODY;
                        end
                        else if (item.plus)
                            phase_next = PH_BODY;
                        else
                            body_go = 1'b1;
                    end
                    PH_BODY:
                        body_go = 1'b1;
                    PH_ZERO:
                    begin
                        if (item.letter_x)
                            phase_next = PH_ZEROX;
                        else
                            take = 1'b1;
                    end
                    PH_ZEROX:
                    begin
                        if (item.digit < BASE_HEX)
                            take = 1'b1;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_DIGITS:
                        take = 1'b1;
                    default:
                        phase_next = phase_reg;
                endcase
                if (body_go)
                begin
                    if (base_bad)
                        phase_next = PH_DONE;
                    else if ((base_cur == BASE_AUTO || base_cur == BASE_HEX) &&
                             item.digit == '0)
                    begin
                        zstart     = 1'b1;
                        phase_next = PH_ZERO;
                    end
                    else
                        take = 1'b1;
                end
                if (take)
                    phase_next = digit_ok ? PH_DIGITS : PH_DONE;
            end
        end
    end

    // parse datapath
    always_comb
    begin
        acc_next        = acc_reg;
        ovf_next        = ovf_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        byte_index_next = byte_index_reg;
        stop_index_next = stop_index_reg;
        digit_seen_next = digit_seen_reg;
        if (pop)
        begin
            if (item.term)
            begin
                acc_next        = '0;
                ovf_next        = 1'b0;
                neg_next        = 1'b0;
                base_next       = BASE_AUTO;
                byte_index_next = '0;
                stop_index_next = '0;
                digit_seen_next = 1'b0;
            end
            else
            begin
                base_next       = base_cur;
                byte_index_next = idx_inc;
                if (neg_set)
                    neg_next = 1'b1;
                if (zstart)
                begin
                    acc_next        = '0;
                    digit_seen_next = 1'b1;
                    stop_index_next = idx_inc;
                    base_next       = (base_cur == BASE_AUTO) ? BASE_OCT : base_cur;
                end
                if (take)
                begin
                    base_next = mul_base;
                    if (digit_ok)
                    begin
                        acc_next        = prod[WORD_BITS-1:0];
                        ovf_next        = ovf_reg || prod_ovf;
                        digit_seen_next = 1'b1;
                        stop_index_next = idx_inc;
                    end
                end
            end
        end
    end

    // result formatting on the terminating byte
    assign lim      = {1'b1, {(WORD_BITS - 1){1'b0}}};
    assign acc_neg  = '0 - acc_reg;
    assign stop_ext = 32'(stop_index_reg);

    always_comb
    begin
        v_word      = '0;
        status_next = ST_OK;
        end_next    = '0;
        value_next  = '0;
        if (base_bad)
            status_next = ST_BAD_BASE;
        else if (!digit_seen_reg)
            status_next = ST_NO_DIGITS;
        else
        begin
            end_next = (stop_ext > 32'h0000_ffff) ? '1 : stop_ext[END_BITS-1:0];
            if (!signed_mode)
            begin
                if (ovf_reg)
                begin
                    v_word      = '1;
                    status_next = ST_RANGE;
                end
                else
                    v_word = neg_reg ? acc_neg : acc_reg;
                value_next = VALUE_BITS'(v_word);
            end
            else
            begin
                if (ovf_reg || acc_reg > lim || (acc_reg == lim && !neg_reg))
                begin
                    v_word      = neg_reg ? lim : lim - 1'b1;
                    status_next = ST_RANGE;
                end
                else
                    v_word = neg_reg ? acc_neg : acc_reg;
                value_next = VALUE_BITS'($signed(v_word));
            end
        end
    end

    assign out_valid_next = finish || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SPACE;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            neg_reg        <= 1'b0;
            base_reg       <= BASE_AUTO;
            byte_index_reg <= '0;
            stop_index_reg <= '0;
            digit_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
            neg_reg        <= neg_next;
            base_reg       <= base_next;
            byte_index_reg <= byte_index_next;
            stop_index_reg <= stop_index_next;
            digit_seen_reg <= digit_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            end_reg    <= end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;
    assign end_index = end_reg;

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (phase_reg == PH_SPACE && byte_index_reg == '0 && out_valid_reg))
        else $error("parse state not cleared after terminator");

    a_stop_without_digit: assert property (@(posedge clk) disable iff (!rst_n)
        !digit_seen_reg |-> (stop_index_reg == '0))
        else $error("stop index set with no digit");

    a_stop_le_byte: assert property (@(posedge clk) disable iff (!rst_n)
        stop_index_reg <= byte_index_reg)
        else $error("stop index past byte index");

    a_number_phase_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ZERO || phase_reg == PH_ZEROX || phase_reg == PH_DIGITS)
        |-> digit_seen_reg)
        else $error("number phase without digit");

endmodule

`default_nettype wire

// ===== rtl/text_to_integer_parser_unit.sv =====
// Text to integer parser, top level: configuration registers, front end, queue, back end.
// Depends on tip_pkg, tip_front, tip_queue and tip_back.
//
// Usage:
//   Bytes of a string arrive on in_valid/in_ready/char_in, one per cycle while
//   in_ready is high. A zero byte ends the string and yields exactly one result
//   on out_valid/out_ready with value, status and end_index; other bytes yield none.
//   Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data; index 0 is the number
//   base (0 = auto, 2..36), index 1 the signed mode. cfg_ready is always high.
//   Write only while no string is in flight; the base is sampled on a string's
//   first byte.
//   Throughput: one byte per cycle while the queue is not full. The loop that sets
//   it is the accumulator update, a 64 x 6 multiply-add per digit.
//   Result path: the result register is loaded the cycle a zero byte leaves the
//   4-entry queue; a terminating byte is written into a queue entry, then loaded
//   into the result register, and out_valid rises once that register is loaded.
//   Stall: while a result waits on out_ready, non-terminating bytes keep being
//   parsed; a second terminator waits in the queue, and in_ready drops only
//   when the queue is full.
//   Reset: queue empty, no result pending, parser at leading whitespace,
//   base register 10, unsigned mode.
`default_nettype none

module text_to_integer_parser_unit
    import tip_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [CHAR_BITS-1:0]    char_in,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [VALUE_BITS-1:0]        value,
    output logic [STATUS_BITS-1:0]       status,
    output logic [END_BITS-1:0]          end_index,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [BASE_BITS-1:0]    cfg_data
);

    logic [BASE_BITS-1:0] number_base_reg;
    logic [BASE_BITS-1:0] number_base_next;
    logic                 signed_mode_reg;
    logic                 signed_mode_next;

    logic      push;
    logic      pop;
    logic      q_full;
    logic      q_empty;
    tip_item_t wr_item;
    tip_item_t rd_item;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        number_base_next = number_base_reg;
        signed_mode_next = signed_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUMBER_BASE: number_base_next = cfg_data;
                CFG_SIGNED_MODE: signed_mode_next = cfg_data[0];
                default:         number_base_next = number_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_RESET;
            signed_mode_reg <= 1'b0;
        end
        else
        begin
            number_base_reg <= number_base_next;
            signed_mode_reg <= signed_mode_next;
        end
    end

    tip_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .number_base (number_base_reg),
        .q_full      (q_full),
        .push        (push),
        .item        (wr_item)
    );

    tip_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .full    (q_full),
        .pop     (pop),
        .empty   (q_empty),
        .rd_item (rd_item)
    );

    tip_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (rd_item),
        .empty       (q_empty),
        .pop         (pop),
        .signed_mode (signed_mode_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .value       (value),
        .status      (status),
        .end_index   (end_index)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for text_to_integer_parser_unit: directed strings, then random ones.
// A behavioral parser in this file predicts every result. Depends on tip_pkg and the RTL.
// Idle gaps and output stalls are random; configuration changes only between idle phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tip_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES  = 1200;
    localparam int CALM_FROM     = 500;
    localparam int CALM_TO       = 800;
    localparam logic [BASE_BITS-1:0] BASE_BIN = 6'd2;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        status_t               status;
        logic [END_BITS-1:0]   end_index;
    } parse_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [CHAR_BITS-1:0]    char_in;
    logic                    out_valid;
    logic                    out_ready;
    logic [VALUE_BITS-1:0]   value;
    logic [STATUS_BITS-1:0]  status;
    logic [END_BITS-1:0]     end_index;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [BASE_BITS-1:0]    cfg_data;

    // predicted parser state and register copies
    phase_t                 p_phase;
    logic [WORD_BITS-1:0]   p_acc;
    logic                   p_ovf;
    logic                   p_neg;
    logic [BASE_BITS-1:0]   p_base;
    logic [INDEX_BITS-1:0]  p_bidx;
    logic [INDEX_BITS-1:0]  p_sidx;
    logic                   p_dseen;
    logic [BASE_BITS-1:0]   reg_base;
    logic                   reg_signed;

    parse_result_t          results_due[$];
    parse_result_t          head_due;
    logic [CHAR_BITS-1:0]   line_buf[$];
    int                     faults;
    int                     bytes_sent;
    bit                     calm;

    text_to_integer_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .status    (status),
        .end_index (end_index),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("text_to_integer_parser_unit verification failed");
        $finish;
    end

    // ---------------- parser prediction ----------------

    function automatic logic [DIGIT_BITS-1:0] digit_val(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] t;
        t = c | 8'h20;
        if (c >= "0" && c <= "9")
        begin
            t = c - 8'h30;
            return t[DIGIT_BITS-1:0];
        end
        if (t >= "a" && t <= "z")
        begin
            t = t - 8'h61 + 8'd10;
            return t[DIGIT_BITS-1:0];
        end
        return '1;
    endfunction

    function automatic logic is_blank(input logic [CHAR_BITS-1:0] c);
        return (c >= 8'h09 && c <= 8'h0d) || c == 8'h20;
    endfunction

    function automatic logic bad_radix(input logic [BASE_BITS-1:0] b);
        return b == BASE_ONE || b > BASE_MAX;
    endfunction

    function automatic logic [INDEX_BITS-1:0] bump_index(input logic [INDEX_BITS-1:0] i);
        return (&i) ? i : i + 1'b1;
    endfunction

    task automatic add_digit(input logic [CHAR_BITS-1:0] c);
        logic [DIGIT_BITS-1:0] d;
        logic [WORD_BITS-1:0]  d64;
        logic [WORD_BITS-1:0]  b64;
        d = digit_val(c);
        d64 = WORD_BITS'(d);
        b64 = WORD_BITS'(p_base);
        if (p_base < BASE_BIN || d >= p_base)
            p_phase = PH_DONE;
        else
        begin
            if (p_acc > ({WORD_BITS{1'b1}} - d64) / b64)
                p_ovf = 1'b1;
            p_acc = p_acc * b64 + d64;
            p_dseen = 1'b1;
            p_sidx = bump_index(p_bidx);
            p_phase = PH_DIGITS;
        end
    endtask

    // first byte after blanks and sign: a leading zero may start a prefix
    task automatic open_number(input logic [CHAR_BITS-1:0] c);
        if (bad_radix(p_base))
            p_phase = PH_DONE;
        else if ((p_base == BASE_AUTO || p_base == BASE_HEX) && c == "0")
        begin
            p_dseen = 1'b1;
            p_acc = '0;
            p_sidx = bump_index(p_bidx);
            if (p_base == BASE_AUTO)
                p_base = BASE_OCT;
            p_phase = PH_ZERO;
        end
        else
        begin
            if (p_base == BASE_AUTO)
                p_base = BASE_DEC;
            add_digit(c);
        end
    endtask

    task automatic clear_parse();
        p_phase = PH_SPACE;
        p_acc = '0;
        p_ovf = 1'b0;
        p_neg = 1'b0;
        p_base = '0;
        p_bidx = '0;
        p_sidx = '0;
        p_dseen = 1'b0;
    endtask

    task automatic parse_byte(input logic [CHAR_BITS-1:0] c);
        parse_result_t        res;
        logic [WORD_BITS-1:0] lim;
        lim = {1'b1, {(WORD_BITS-1){1'b0}}};
        if (p_phase == PH_SPACE && p_bidx == 0)
            p_base = reg_base;
        if (c == CHAR_NUL)
        begin
            res.value = '0;
            res.status = ST_OK;
            res.end_index = '0;
            if (bad_radix(p_base))
                res.status = ST_BAD_BASE;
            else if (!p_dseen)
                res.status = ST_NO_DIGITS;
            else
            begin
                res.end_index = p_sidx;
                if (!reg_signed)
                begin
                    if (p_ovf)
                    begin
                        res.value = '1;
                        res.status = ST_RANGE;
                    end
                    else
                        res.value = p_neg ? 64'd0 - p_acc : p_acc;
                end
                else if (p_ovf || p_acc > lim || (p_acc == lim && !p_neg))
                begin
                    res.value = p_neg ? lim : lim - 64'd1;
                    res.status = ST_RANGE;
                end
                else
                    res.value = p_neg ? 64'd0 - p_acc : p_acc;
            end
            results_due.push_back(res);
            clear_parse();
        end
        else
        begin
            case (p_phase)
                PH_SPACE:
                begin
                    if (!is_blank(c))
                    begin
                        if (c == CHAR_MINUS)
                        begin
                            p_neg = 1'b1;
                            p_phase = PH_BODY;
                        end
                        else if (c == CHAR_PLUS)
                            p_phase = PH_BODY;
                        else
                            open_number(c);
                    end
                end
                PH_BODY:
                    open_number(c);
                PH_ZERO:
                begin
                    if (c == CHAR_X_LO || c == CHAR_X_UP)
                        p_phase = PH_ZEROX;
                    else
                        add_digit(c);
                end
                PH_ZEROX:
                begin
                    if (digit_val(c) < 16)
                    begin
                        p_base = BASE_HEX;
                        add_digit(c);
                    end
                    else
                        p_phase = PH_DONE;
                end
                PH_DIGITS:
                    add_digit(c);
                default:
                    ;
            endcase
            p_bidx = bump_index(p_bidx);
        end
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result with none expected: value %h status %0d end_index %0d",
                         $time, value, status, end_index);
                faults++;
            end
            else
            begin
                head_due = results_due.pop_front();
                if (value !== head_due.value)
                begin
                    $display("%0t: value expected %h actual %h", $time, head_due.value, value);
                    faults++;
                end
                if (status !== head_due.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, head_due.status, status);
                    faults++;
                end
                if (end_index !== head_due.end_index)
                begin
                    $display("%0t: end_index expected %0d actual %0d",
                             $time, head_due.end_index, end_index);
                    faults++;
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 27);

    // ---------------- drivers ----------------

    task automatic send_byte(input logic [CHAR_BITS-1:0] c);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(c);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        send_byte(CHAR_NUL);
        line_buf.delete();
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
        send_line();
    endtask

    // drop valid, drain every result, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [BASE_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_NUMBER_BASE)
            reg_base = data;
        else
            reg_signed = data[0];
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic reconfigure(input logic [BASE_BITS-1:0] base_sel, input logic sign_sel);
        logic [BASE_BITS-2:0] pad;
        pad = (BASE_BITS-1)'($urandom);
        wait_idle();
        write_reg(CFG_NUMBER_BASE, base_sel);
        write_reg(CFG_SIGNED_MODE, {pad, sign_sel});
    endtask

    function automatic logic [CHAR_BITS-1:0] digit_char(input int d, input bit up);
        if (d < 10)
            return CHAR_BITS'(8'h30 + d);
        return CHAR_BITS'((up ? 8'h41 : 8'h61) + d - 10);
    endfunction

    // ---------------- tests ----------------

    // runs on the reset configuration: decimal, unsigned
    task automatic test_blanks_and_signs();
        send_text("");
        send_text(" \011\012\015\014\013-123");
        send_text("+42");
        send_text("-");
        send_text("+");
        send_text("12ab\377 9");
        send_text("\377");
    endtask

    task automatic test_auto_base();
        reconfigure(BASE_AUTO, 1'b0);
        send_text("0x1A");
        send_text("0X");
        send_text("0xg");
        send_text("017");
        send_text("089");
        send_text("-0x10");
        send_text("987");
    endtask

    task automatic test_hex_prefix();
        reconfigure(BASE_HEX, 1'b0);
        send_text("0X7fFF");
        send_text("ff");
        send_text("0xz");
    endtask

    task automatic test_radix_extremes();
        reconfigure(BASE_BIN, 1'b0);
        send_text("1012");
        reconfigure(BASE_MAX, 1'b1);
        send_text("zZ");
        send_text("-zz");
    endtask

    task automatic test_unsigned_limits();
        reconfigure(BASE_DEC, 1'b0);
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("-1");
    endtask

    task automatic test_signed_limits();
        reconfigure(BASE_DEC, 1'b1);
        send_text("9223372036854775807");
        send_text("9223372036854775808");
        send_text("-9223372036854775808");
        send_text("-9223372036854775809");
        send_text("-99999999999999999999");
    endtask

    task automatic test_bad_base();
        reconfigure(BASE_ONE, 1'b0);
        send_text("123");
        reconfigure(BASE_MAX + 6'd1, 1'b1);
        send_text("");
        reconfigure('1, 1'b0);
        send_text("5");
    endtask

    // random strings until the byte budget is used; one stretch runs without gaps or stalls
    task automatic test_random_text();
        int                   left_in_phase;
        int                   eb;
        int                   n;
        int                   k;
        logic [BASE_BITS-1:0] nb;
        left_in_phase = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (left_in_phase == 0)
            begin
                case ($urandom_range(9))
                    0, 1: nb = BASE_AUTO;
                    2: nb = BASE_BIN;
                    3: nb = BASE_MAX;
                    4: nb = BASE_HEX;
                    5: nb = BASE_ONE;
                    6: nb = BASE_BITS'($urandom_range(37, 63));
                    default: nb = BASE_BITS'($urandom_range(2, 35));
                endcase
                reconfigure(nb, 1'($urandom_range(1)));
                left_in_phase = $urandom_range(6, 20);
            end
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(0, 10))
                    line_buf.push_back(CHAR_BITS'($urandom_range(1, 255)));
            end
            else
            begin
                repeat ($urandom_range(0, 3))
                begin
                    k = $urandom_range(5);
                    line_buf.push_back(k == 5 ? 8'h20 : CHAR_BITS'(8'h09 + k));
                end
                case ($urandom_range(3))
                    0: line_buf.push_back(CHAR_PLUS);
                    1: line_buf.push_back(CHAR_MINUS);
                    default: ;
                endcase
                eb = int'(reg_base);
                if (reg_base == BASE_AUTO)
                begin
                    case ($urandom_range(2))
                        0:
                        begin
                            line_buf.push_back("0");
                            line_buf.push_back($urandom_range(1) ? CHAR_X_LO : CHAR_X_UP);
                            eb = 16;
                        end
                        1:
                        begin
                            line_buf.push_back("0");
                            eb = 8;
                        end
                        default:
                            eb = 10;
                    endcase
                end
                else if (reg_base == BASE_HEX && $urandom_range(1))
                begin
                    line_buf.push_back("0");
                    line_buf.push_back($urandom_range(1) ? CHAR_X_LO : CHAR_X_UP);
                end
                else if (bad_radix(reg_base))
                    eb = 36;
                // short numbers half the time, else lengths up to enough to overflow
                if ($urandom_range(1))
                    n = $urandom_range(0, 5);
                else
                    n = $urandom_range(0, eb == 2 ? 68 : eb < 8 ? 44 : eb < 16 ? 26 : 18);
                repeat (n) line_buf.push_back(digit_char($urandom_range(eb - 1),
                                                         1'($urandom_range(1))));
                if ($urandom_range(2) == 0)
                    repeat ($urandom_range(1, 4))
                        line_buf.push_back(CHAR_BITS'($urandom_range(1, 255)));
            end
            calm = (bytes_sent >= CALM_FROM) && (bytes_sent < CALM_TO);
            send_line();
            left_in_phase--;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_in = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NUMBER_BASE;
        cfg_data = '0;
        calm = 1'b0;
        faults = 0;
        bytes_sent = 0;
        reg_base = BASE_RESET;
        reg_signed = 1'b0;
        clear_parse();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_blanks_and_signs();
        test_auto_base();
        test_hex_prefix();
        test_radix_extremes();
        test_unsigned_limits();
        test_signed_limits();
        test_bad_base();
        test_random_text();

        wait_idle();
        if (faults == 0)
            $display("text_to_integer_parser_unit verification clean");
        else
            $display("text_to_integer_parser_unit verification failed");
        $finish;
    end

endmodule

// ===== text_to_integer_parser_unit.f =====
rtl/tip_pkg.sv
rtl/tip_front.sv
rtl/tip_queue.sv
rtl/tip_back.sv
rtl/text_to_integer_parser_unit.sv
dv/tb.sv
